### hw/rtl/ccem_pkg.sv
// shared types and constants for the colour-consistent edge map
`timescale 1ns / 1ps
`default_nettype none

package ccem_pkg;

  typedef enum logic [1:0] {
    REG_MIN_GRAD     = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam logic [7:0] MapEdge    = 8'd0;
  localparam logic [7:0] MapNoEdge  = 8'd255;

  localparam logic [7:0]  MinGradReset     = 8'd0;
  localparam logic [11:0] FrameWidthReset  = 12'd640;
  localparam logic [15:0] FrameHeightReset = 16'd480;

endpackage

`default_nettype wire

### hw/rtl/color_consistent_edge_map.sv
// top level of the colour-consistent edge map over a raster rgb stream
// an input transfer passes the compare stage register and then the output register before its map pixel is transferred
// throughput: one pixel per cycle while the output is not stalled; the line store has one write and one read per pixel
// the output register stalls the whole pipeline only while its result is not taken
// reset clears counters, left pixel, pipeline valids and loads register defaults
// line store contents are not cleared; every entry below the effective frame width is written in the first row
`timescale 1ns / 1ps
`default_nettype none

module color_consistent_edge_map #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // blue [7:0], green [15:8], red [23:16]
  input  wire logic [23:0] s_axis_tdata_i,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // edge_value [7:0]
  output      logic [7:0]  m_axis_tdata_o,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import ccem_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = (AW + 1 > 13) ? AW + 1 : 13;
  localparam logic [CW-1:0] MaxW = CW'(MAX_WIDTH);

  // configuration registers
  logic [7:0]  min_grad_q;
  logic [11:0] frame_width_q;
  logic [15:0] frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_grad_q     <= MinGradReset;
      frame_width_q  <= FrameWidthReset;
      frame_height_q <= FrameHeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_MIN_GRAD:     min_grad_q     <= cfg_data_i[7:0];
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[11:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic en;
  logic s_acc;
  logic out_valid_q;

  assign en              = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign s_acc           = s_axis_tvalid_i && en;

  // effective frame size
  logic [CW-1:0] fw_ext;
  logic [CW-1:0] w_eff;
  logic [15:0]   h_eff;

  assign fw_ext = CW'(frame_width_q);
  assign w_eff  = (fw_ext == '0) ? CW'(1) : ((fw_ext > MaxW) ? MaxW : fw_ext);
  assign h_eff  = (frame_height_q == '0) ? 16'd1 : frame_height_q;

  // position counters
  logic [AW-1:0] col_q, col_d;
  logic [15:0]   row_q, row_d;
  logic [CW-1:0] col_ext;
  logic          border;

  assign col_ext = CW'(col_q);
  assign border  = (col_q == '0) || (row_q == '0) ||
                   (col_ext >= w_eff - CW'(1)) || (row_q >= h_eff - 16'd1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (col_ext + CW'(1) >= w_eff) begin
      col_d = '0;
      if ({1'b0, row_q} + 17'd1 >= {1'b0, h_eff}) begin
        row_d = '0;
      end else begin
        row_d = row_q + 16'd1;
      end
    end else begin
      col_d = col_q + AW'(1);
    end
  end

  pixel_t cur_px;
  pixel_t left_q;

  assign cur_px = pixel_t'(s_axis_tdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (s_acc) begin
      col_q  <= col_d;
      row_q  <= row_d;
      left_q <= cur_px;
    end
  end

  // line store: old data read and new pixel written at the same column
  logic [23:0] line_mem [MAX_WIDTH];
  pixel_t      above_q;

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      above_q        <= pixel_t'(line_mem[col_q]);
      line_mem[col_q] <= s_axis_tdata_i;
    end
  end

  // compare stage
  logic   s1_valid_q;
  logic   s1_border_q;
  pixel_t s1_cur_q;
  pixel_t s1_left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      s1_border_q <= border;
      s1_cur_q    <= cur_px;
      s1_left_q   <= left_q;
    end
  end

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    abs_diff = (a > b) ? a - b : b - a;
  endfunction

  // consistent sign and sum at or above threshold means score above min_grad
  function automatic logic pair_hit(input pixel_t a, input pixel_t b,
                                    input logic [9:0] bound);
    logic [2:0] up;
    logic [2:0] dn;
    logic [9:0] sum;
    up  = {a.red > b.red, a.green > b.green, a.blue > b.blue};
    dn  = {a.red < b.red, a.green < b.green, a.blue < b.blue};
    sum = 10'(abs_diff(a.red, b.red)) + 10'(abs_diff(a.green, b.green)) +
          10'(abs_diff(a.blue, b.blue));
    pair_hit = ((&up) || (&dn)) && (sum >= bound);
  endfunction

  logic [9:0] thr;
  logic       is_edge;
  logic [7:0] map_px;

  assign thr     = {1'b0, min_grad_q, 1'b0} + {2'b00, min_grad_q} + 10'd3;
  assign is_edge = pair_hit(s1_cur_q, s1_left_q, thr) || pair_hit(s1_cur_q, above_q, thr);
  assign map_px  = (s1_border_q || is_edge) ? MapEdge : MapNoEdge;

  // output register
  logic [7:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s1_valid_q) begin
      out_data_q <= map_px;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_border_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && s1_valid_q && s1_border_q) |=> (m_axis_tdata_o == MapEdge))
    else $error("border pixel not mapped to edge");

  a_accept_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> s1_valid_q)
    else $error("accepted pixel lost in compare stage");

  a_stall_blocks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input taken while output stalled");

  a_map_levels : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (m_axis_tdata_o == MapEdge || m_axis_tdata_o == MapNoEdge))
    else $error("map pixel outside two levels");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// testbench for the colour-consistent edge map: directed frame table, then random frames
`timescale 1ns / 1ps

module testbench;
  import ccem_pkg::*;

  localparam int MaxWidth = 2048;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef enum logic {
    ROW_PIXEL,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    logic [23:0] px;
    logic        typed;
    logic [7:0]  map_px;
  } step_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic [23:0] s_tdata = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  m_tdata;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // edge map predictor state
  logic [23:0] line_store [MaxWidth];
  logic [23:0] left_px;
  int unsigned col_cnt;
  int unsigned row_cnt;
  int unsigned hi_written;
  logic [7:0]  min_grad;
  logic [11:0] frame_w;
  logic [15:0] frame_h;

  logic [7:0]  map_q [$];
  logic [7:0]  want_map;
  logic [23:0] last_px = '0;
  step_t       dir_tab [$];
  int unsigned err_cnt = 0;
  int unsigned out_cnt = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  always #1 clk = ~clk;

  color_consistent_edge_map #(
    .MAX_WIDTH(MaxWidth)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  function automatic int unsigned eff_width(logic [11:0] w);
    if (w == 0) return 1;
    if (w > MaxWidth) return MaxWidth;
    return w;
  endfunction

  function automatic int unsigned pair_score(logic [23:0] a, logic [23:0] b);
    int unsigned total;
    int unsigned ups;
    int unsigned downs;
    int k;
    total = 0;
    ups = 0;
    downs = 0;
    for (k = 0; k < 3; k++) begin
      if (a[8*k +: 8] > b[8*k +: 8]) begin
        ups++;
        total += a[8*k +: 8] - b[8*k +: 8];
      end else if (a[8*k +: 8] < b[8*k +: 8]) begin
        downs++;
        total += b[8*k +: 8] - a[8*k +: 8];
      end
    end
    return (ups == 3 || downs == 3) ? total / 3 : 0;
  endfunction

  function automatic logic [7:0] predict_map(logic [23:0] px);
    int unsigned w;
    int unsigned h;
    int unsigned s_left;
    int unsigned s_up;
    int unsigned best;
    logic [7:0] res;
    w = eff_width(frame_w);
    h = (frame_h == 0) ? 1 : frame_h;
    res = MapEdge;
    if (!(col_cnt == 0 || row_cnt == 0 || col_cnt >= w - 1 || row_cnt >= h - 1)) begin
      s_left = pair_score(px, left_px);
      s_up = pair_score(px, line_store[col_cnt % MaxWidth]);
      best = (s_left > s_up) ? s_left : s_up;
      res = (best > min_grad) ? MapEdge : MapNoEdge;
    end
    line_store[col_cnt % MaxWidth] = px;
    left_px = px;
    if (col_cnt + 1 > hi_written) hi_written = col_cnt + 1;
    if (col_cnt + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (row_cnt + 1 >= h) ? 0 : row_cnt + 1;
    end else begin
      col_cnt++;
    end
    return res;
  endfunction

  function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_MIN_GRAD: min_grad = val[7:0];
      REG_FRAME_WIDTH: frame_w = val[11:0];
      REG_FRAME_HEIGHT: frame_h = val;
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
  endfunction

  // neighbour-like pixels reach the same-sign and threshold cases far more often
  function automatic logic [23:0] next_pixel(logic [23:0] prev);
    logic [23:0] px;
    int mode;
    int k;
    int d;
    int v;
    bit up;
    mode = $urandom_range(0, 9);
    if (mode < 3) return 24'($urandom);
    if (mode == 3) begin
      for (k = 0; k < 3; k++) px[8*k +: 8] = $urandom_range(0, 1) ? 8'hff : 8'h00;
      return px;
    end
    up = 1'($urandom_range(0, 1));
    for (k = 0; k < 3; k++) begin
      d = (mode < 7) ? $urandom_range(1, 14) : $urandom_range(0, 8);
      if (mode >= 7) up = 1'($urandom_range(0, 1));
      v = up ? prev[8*k +: 8] + d : prev[8*k +: 8] - d;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      px[8*k +: 8] = v[7:0];
    end
    return px;
  endfunction

  function automatic step_t mk_pix(logic [7:0] b, logic [7:0] g, logic [7:0] r,
                                   logic typed, logic [7:0] map_px);
    step_t s;
    s = '0;
    s.kind = ROW_PIXEL;
    s.px = {r, g, b};
    s.typed = typed;
    s.map_px = map_px;
    return s;
  endfunction

  function automatic step_t mk_wr(logic [1:0] idx, logic [15:0] val);
    step_t s;
    s = '0;
    s.kind = ROW_WRITE;
    s.reg_idx = idx;
    s.reg_val = val;
    return s;
  endfunction

  function automatic void put_row(step_t s);
    dir_tab = {dir_tab, s};
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: %s", msg);
    err_cnt++;
  endtask

  task automatic feed(logic [23:0] px, int gap, logic typed, logic [7:0] map_px);
    logic [7:0] m;
    int g;
    for (g = 0; g < gap; g++) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    m = predict_map(px);
    map_q = {map_q, (typed ? map_px : m)};
    last_px = px;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (map_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else begin
      m_tready <= 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (map_q.size() == 0) begin
        report_mismatch($sformatf("map pixel %0d arrived with none expected", out_cnt));
      end else begin
        want_map = map_q.pop_front();
        if (m_tdata !== want_map)
          report_mismatch($sformatf("map pixel %0d: got %0d, expected %0d",
                                    out_cnt, m_tdata, want_map));
      end
      out_cnt++;
    end
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int p;
    int i;
    int len;
    logic [15:0] mg;
    logic [15:0] wv;
    logic [15:0] hv;

    min_grad = MinGradReset;
    frame_w = FrameWidthReset;
    frame_h = FrameHeightReset;
    left_px = '0;
    col_cnt = 0;
    row_cnt = 0;
    hi_written = 0;
    for (i = 0; i < MaxWidth; i++) line_store[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default width: first row is all border; then a 5 x 4 frame with min_grad 10
    put_row(mk_pix(8'd255, 8'd255, 8'd255, 1'b1, MapEdge));
    put_row(mk_pix(8'd0,   8'd0,   8'd0,   1'b1, MapEdge));
    put_row(mk_wr(REG_MIN_GRAD, 16'd10));
    put_row(mk_wr(REG_FRAME_WIDTH, 16'd5));
    put_row(mk_wr(REG_FRAME_HEIGHT, 16'd4));
    put_row(mk_pix(8'd100, 8'd100, 8'd100, 1'b1, MapEdge));
    put_row(mk_pix(8'd100, 8'd99,  8'd131, 1'b1, MapEdge));
    put_row(mk_pix(8'd255, 8'd255, 8'd255, 1'b1, MapEdge));
    put_row(mk_pix(8'd0,   8'd0,   8'd0,   1'b1, MapEdge));
    put_row(mk_pix(8'd130, 8'd130, 8'd130, 1'b0, MapEdge));
    put_row(mk_pix(8'd101, 8'd100, 8'd130, 1'b0, MapEdge));
    put_row(mk_pix(8'd100, 8'd101, 8'd129, 1'b0, MapEdge));
    put_row(mk_pix(8'd255, 8'd0,   8'd255, 1'b1, MapEdge));
    put_row(mk_pix(8'd130, 8'd130, 8'd130, 1'b1, MapEdge));
    put_row(mk_pix(8'd140, 8'd140, 8'd141, 1'b0, MapEdge));
    put_row(mk_pix(8'd111, 8'd112, 8'd141, 1'b0, MapEdge));
    put_row(mk_pix(8'd0,   8'd255, 8'd0,   1'b0, MapEdge));
    put_row(mk_pix(8'd0,   8'd0,   8'd0,   1'b1, MapEdge));
    put_row(mk_pix(8'd255, 8'd255, 8'd255, 1'b1, MapEdge));
    put_row(mk_pix(8'd1,   8'd2,   8'd3,   1'b1, MapEdge));
    put_row(mk_pix(8'd0,   8'd0,   8'd0,   1'b1, MapEdge));
    put_row(mk_pix(8'd200, 8'd100, 8'd50,  1'b1, MapEdge));
    put_row(mk_pix(8'd7,   8'd7,   8'd7,   1'b1, MapEdge));

    for (i = 0; i < dir_tab.size(); i++) begin
      if (dir_tab[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        feed(dir_tab[i].px, sender_gap(), dir_tab[i].typed, dir_tab[i].map_px);
      end
    end

    for (p = 0; p < 17; p++) begin
      len = $urandom_range(25, 50);
      case (p)
        0: begin mg = 16'd0; wv = 16'd3; hv = 16'd3; end
        1: begin mg = 16'd255; wv = 16'd8; hv = 16'd5; end
        2: begin mg = 16'hff28; wv = 16'hf000; hv = 16'd4; end
        3: begin mg = 16'd20; wv = 16'd2; hv = 16'd3; end
        4: begin mg = 16'd30; wv = 16'd6; hv = 16'd1; end
        5: begin mg = 16'd15; wv = 16'd10; hv = 16'd2; end
        6: begin mg = 16'd20; wv = 16'd7; hv = 16'd0; end
        7: begin mg = 16'd25; wv = 16'd4095; hv = 16'd3; end
        8: begin mg = 16'd60; wv = 16'd5; hv = 16'hffff; end
        9: begin mg = 16'd10; wv = 16'd2048; hv = 16'd3; end
        default: begin
          mg = 16'($urandom_range(0, 60));
          wv = 16'($urandom_range(3, 12));
          hv = 16'($urandom_range(3, 8));
        end
      endcase
      wait_idle();
      calm = ($urandom_range(0, 3) == 0);
      // a wider row must not read line store entries that were never written
      if (row_cnt != 0 && eff_width(wv[11:0]) > hi_written + 1) hv = row_cnt[15:0];
      write_reg(REG_MIN_GRAD, mg);
      write_reg(REG_FRAME_WIDTH, wv);
      write_reg(REG_FRAME_HEIGHT, hv);
      if (p == 10) write_reg(RegUnused, 16'($urandom));
      for (i = 0; i < len; i++) begin
        if (p == 5 && i == len / 2) wait_idle();
        feed(next_pixel(last_px), sender_gap(), 1'b0, MapEdge);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
